// ===== sv/fas_pkg.sv =====
// ----------------------------------------------------------------------------
// Fitting alignment scorer package
// Shared widths, opcodes, register indexes, defaults and score saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package fas_pkg;

	// Field widths of the channels.
	localparam int OP_W       = 2;
	localparam int SYM_W      = 8;
	localparam int SCORE_W    = 13;
	localparam int END_COL_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int MATCH_W    = 4;
	localparam int PEN_W      = 5;

	// Width of intermediate cell sums before saturation.
	localparam int SUM_W = SCORE_W + 2;

	// Parameter defaults.
	localparam int MAX_QUERY_DEF   = 64;
	localparam int COLUMN_BITS_DEF = 16;

	// Item opcodes.
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd0;
	localparam logic [OP_W-1:0] OP_SUBJECT = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;

	// Register reset values.
	localparam logic [MATCH_W-1:0]       MATCH_RST    = 4'd2;
	localparam logic signed [PEN_W-1:0]  MISMATCH_RST = -5'sd2;
	localparam logic signed [PEN_W-1:0]  GAP_RST      = -5'sd1;

	// Score limits.
	localparam logic signed [SUM_W-1:0] SCORE_HI = 15'sd4095;
	localparam logic signed [SUM_W-1:0] SCORE_LO = -15'sd4096;

	// Clamp a widened sum to the score range.
	function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] c;
		c = v;
		if (v > SCORE_HI) begin
			c = SCORE_HI;
		end else if (v < SCORE_LO) begin
			c = SCORE_LO;
		end
		return SCORE_W'(c);
	endfunction

endpackage

`default_nettype wire

// ===== sv/fas_if.sv =====
// ----------------------------------------------------------------------------
// Fitting alignment scorer channels
// Item, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

// Input items: query loads, subject bytes and query clears.
interface fas_item_if import fas_pkg::*;;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [SYM_W-1:0]   symbol;
	logic               last_subject;

	modport source (output valid, opcode, symbol, last_subject, input ready);
	modport sink   (input valid, opcode, symbol, last_subject, output ready);
endinterface

// Result items: one per completed subject run.
interface fas_result_if import fas_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] best_score;
	logic [END_COL_W-1:0]      end_column;
	logic                      last;

	modport source (output valid, best_score, end_column, last, input ready);
	modport sink   (input valid, best_score, end_column, last, output ready);
endinterface

// Configuration register writes.
interface fas_cfg_if import fas_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/fitting_alignment_scorer.sv =====
// ----------------------------------------------------------------------------
// Fitting alignment scorer
// Scores the whole query against any substring of a streamed subject with
// linear gaps; reports the best last-row score and its end column.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Carries
//  -------  ---------  ---------------------------------------------------
//  item     in         opcode, symbol, last_subject
//  result   out        best_score, end_column, last
//  cfg      in         index, data (match, mismatch, gap registers)
//
//  Query loads, clears and unused opcodes are taken in the idle state.
//  A subject byte is accepted, walks the query rows one at a time through
//  the single read port of the column memory, then finishes.
//  Reset is asynchronous and needs no clearing pass; memory data is
//  only used from rows already written.
//  A final subject byte waits in its finish cycle while an earlier result
//  is still held in the output register.
//
`default_nettype none

module fitting_alignment_scorer import fas_pkg::*; #(
	parameter int MAX_QUERY   = MAX_QUERY_DEF,
	parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	fas_item_if.sink      item,
	fas_result_if.source  result,
	fas_cfg_if.sink       cfg
);

	localparam int AW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
	localparam int LW = $clog2(MAX_QUERY + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_WALK   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t                    state_q;
	logic [LW-1:0]             qlen_q;
	logic [COLUMN_BITS-1:0]    col_q;
	logic signed [SCORE_W-1:0] best_q;
	logic [COLUMN_BITS-1:0]    bcol_q;
	logic                      first_col_q;
	logic [LW-1:0]             iss_q;
	logic                      v_s1;
	logic                      last_s1;
	logic [AW-1:0]             row_s1;
	logic                      res_vld_q;

	logic [MATCH_W-1:0]        match_q;
	logic signed [PEN_W-1:0]   mismatch_q;
	logic signed [PEN_W-1:0]   gap_q;

	logic [SYM_W-1:0]          sym_q;
	logic                      last_q;
	logic signed [SCORE_W-1:0] above_q;
	logic signed [SCORE_W-1:0] diag_q;
	logic signed [SCORE_W-1:0] init_q;
	logic signed [SCORE_W-1:0] lastrow_q;
	logic signed [SCORE_W-1:0] res_score_q;
	logic [END_COL_W-1:0]      res_col_q;

	logic [SYM_W-1:0]          qs_mem [MAX_QUERY];
	logic signed [SCORE_W-1:0] pc_mem [MAX_QUERY];
	logic [SYM_W-1:0]          qs_rd_s1;
	logic signed [SCORE_W-1:0] pc_rd_s1;

	logic                      acc;
	logic                      start;
	logic                      qs_we;
	logic                      issue;
	logic [AW-1:0]             rd_addr;
	logic [LW-1:0]             iss_row;
	logic                      iss_last;
	logic                      cell_vld;
	logic signed [SCORE_W-1:0] old_s1;
	logic signed [SUM_W-1:0]   d_w;
	logic signed [SUM_W-1:0]   up_w;
	logic signed [SUM_W-1:0]   left_w;
	logic signed [SUM_W-1:0]   dg_w;
	logic signed [SUM_W-1:0]   mx_w;
	logic signed [SCORE_W-1:0] m_s1;
	logic signed [SCORE_W-1:0] init_next;
	logic                      better;
	logic signed [SCORE_W-1:0] nbest;
	logic [COLUMN_BITS-1:0]    ncol;
	logic                      finish_ok;
	logic                      res_load;

	// Handshake and issue control.
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign acc        = item.valid && item.ready;
	assign start      = acc && (item.opcode == OP_SUBJECT);
	assign qs_we      = acc && (item.opcode == OP_QUERY) && (col_q == '0)
		&& (qlen_q < LW'(MAX_QUERY));
	assign iss_row    = (state_q == S_IDLE) ? '0 : iss_q;
	assign rd_addr    = iss_row[AW-1:0];
	assign iss_last   = (LW'(iss_row + 1'b1) == qlen_q);
	assign issue      = (start && (qlen_q != '0))
		|| ((state_q == S_WALK) && (iss_q < qlen_q));
	assign cell_vld   = (state_q == S_WALK) && v_s1;

	// One cell of the column: max of up, left and diagonal, then clamp.
	always_comb begin
		old_s1 = first_col_q ? init_q : pc_rd_s1;
		if (qs_rd_s1 == sym_q) begin
			d_w = $signed(SUM_W'(match_q));
		end else begin
			d_w = SUM_W'(mismatch_q);
		end
		up_w   = SUM_W'(above_q) + SUM_W'(gap_q);
		left_w = SUM_W'(old_s1) + SUM_W'(gap_q);
		dg_w   = SUM_W'(diag_q) + d_w;
		mx_w   = up_w;
		if (left_w > mx_w) begin
			mx_w = left_w;
		end
		if (dg_w > mx_w) begin
			mx_w = dg_w;
		end
		m_s1      = sat_score(mx_w);
		init_next = sat_score(SUM_W'(init_q) + SUM_W'(gap_q));
	end

	// Best-score update at the end of a column.
	assign better    = lastrow_q > best_q;
	assign nbest     = better ? lastrow_q : best_q;
	assign ncol      = better ? col_q : bcol_q;
	assign finish_ok = (state_q == S_FINISH) && (!last_q || !res_vld_q || result.ready);
	assign res_load  = finish_ok && last_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			qlen_q      <= '0;
			col_q       <= '0;
			best_q      <= '0;
			bcol_q      <= '0;
			first_col_q <= 1'b0;
			iss_q       <= '0;
			v_s1        <= 1'b0;
			last_s1     <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (issue) begin
				last_s1 <= iss_last;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (item.opcode)
							OP_QUERY: begin
								if (qs_we) begin
									qlen_q <= LW'(qlen_q + 1'b1);
								end
							end
							OP_SUBJECT: begin
								first_col_q <= (col_q == '0);
								if (col_q != '1) begin
									col_q <= col_q + 1'b1;
								end
								iss_q   <= LW'(1);
								state_q <= (qlen_q == '0) ? S_FINISH : S_WALK;
							end
							OP_CLEAR: begin
								qlen_q <= '0;
								col_q  <= '0;
								best_q <= '0;
								bcol_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					if (iss_q < qlen_q) begin
						iss_q <= LW'(iss_q + 1'b1);
					end
					if (cell_vld && last_s1) begin
						// Column zero's last row seeds the best score.
						if (first_col_q) begin
							best_q <= old_s1;
							bcol_q <= '0;
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (finish_ok) begin
						if (last_q) begin
							col_q  <= '0;
							best_q <= '0;
							bcol_q <= '0;
						end else begin
							best_q <= nbest;
							bcol_q <= ncol;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// Output register holds a result until it is taken.
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Scoring registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q    <= MATCH_RST;
			mismatch_q <= MISMATCH_RST;
			gap_q      <= GAP_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MATCH:    match_q    <= cfg.data[MATCH_W-1:0];
				REG_MISMATCH: mismatch_q <= $signed(cfg.data[PEN_W-1:0]);
				REG_GAP:      gap_q      <= $signed(cfg.data[PEN_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// Column walk datapath registers.
	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1 <= rd_addr;
		end
		if (start) begin
			sym_q     <= item.symbol;
			last_q    <= item.last_subject;
			above_q   <= '0;
			diag_q    <= '0;
			init_q    <= SCORE_W'(gap_q);
			lastrow_q <= '0;
		end else if (cell_vld) begin
			above_q <= m_s1;
			diag_q  <= old_s1;
			init_q  <= init_next;
			if (last_s1) begin
				lastrow_q <= m_s1;
			end
		end
		if (res_load) begin
			res_score_q <= nbest;
			res_col_q   <= END_COL_W'(ncol);
		end
	end

	// Query memory: written on loads, read once per row.
	always_ff @(posedge clk) begin
		if (qs_we) begin
			qs_mem[qlen_q[AW-1:0]] <= item.symbol;
		end
		if (issue) begin
			qs_rd_s1 <= qs_mem[rd_addr];
		end
	end

	// Column memory: previous column read a row ahead of the write-back.
	always_ff @(posedge clk) begin
		if (cell_vld) begin
			pc_mem[row_s1] <= m_s1;
		end
		if (issue) begin
			pc_rd_s1 <= pc_mem[rd_addr];
		end
	end

	assign result.valid      = res_vld_q;
	assign result.best_score = res_score_q;
	assign result.end_column = res_col_q;
	assign result.last       = 1'b1;

endmodule

`default_nettype wire

// ===== sv/fas_checker.sv =====
// ----------------------------------------------------------------------------
// Fitting alignment scorer checker
// Port-level assertions on item and result behavior, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fas_checker import fas_pkg::*; (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      item_valid,
	input wire logic                      item_ready,
	input wire logic [OP_W-1:0]           item_opcode,
	input wire logic                      result_valid,
	input wire logic                      result_ready,
	input wire logic signed [SCORE_W-1:0] result_best_score,
	input wire logic [END_COL_W-1:0]      result_end_column,
	input wire logic                      result_last
);

	// A stalled result transaction keeps its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid
			&& $stable(result_best_score) && $stable(result_end_column))
		else $error("result changed while stalled");

	// Every result carries the run marker.
	a_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_last)
		else $error("result without last marker");

	// The block only goes busy after taking a subject byte.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item_ready) |-> $past(item_valid) && ($past(item_opcode) == OP_SUBJECT))
		else $error("busy without a subject transaction");

	// A new result appears only at the end of a busy column.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(item_ready))
		else $error("result appeared while idle");

endmodule

bind fitting_alignment_scorer fas_checker u_fas_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_opcode       (item.opcode),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_best_score (result.best_score),
	.result_end_column (result.end_column),
	.result_last       (result.last)
);

`default_nettype wire
